@@ hw/rtl/ece_pkg.sv @@
// ----------------------------------------------------------------------------
// ece_pkg: shared types and constants of the escape codec
// Token text, token lengths, escaped characters and the command word that
// travels from the classifier to the byte emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package ece_pkg;

	localparam int unsigned NumTok = 4;
	localparam int unsigned TokMax = 9;

	localparam logic [7:0] LT_CHAR = 8'h3C;  // '<'

	// token text, unused tail positions are zero
	localparam logic [7:0] TOK_TEXT [NumTok][TokMax] = '{
		'{"<", "p", "o", "u", "n", "d", ">", 8'h00, 8'h00},
		'{"<", "p", "e", "r", "c", "e", "n", "t", ">"},
		'{"<", "a", "n", "d", ">", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"<", "d", "o", "l", "l", "a", "r", ">", 8'h00}
	};

	localparam logic [3:0] TOK_LEN [NumTok] = '{4'd7, 4'd9, 4'd5, 4'd8};

	localparam logic [7:0] TOK_CHAR [NumTok] = '{"#", "%", "&", "$"};

	// one command: the first n bytes of a token, then an optional literal
	typedef struct packed {
		logic [1:0] tok;
		logic [3:0] n;
		logic       lit_en;
		logic [7:0] lit;
		logic       eom;
	} ece_cmd_t;

	// byte of token k at position pos, zero past the end of the table
	function automatic logic [7:0] tok_byte(input logic [1:0] k, input logic [3:0] pos);
		logic [7:0] res;
		res = 8'h00;
		if (pos < 4'(TokMax)) begin
			res = TOK_TEXT[k][pos];
		end
		return res;
	endfunction

	// lowest set bit of a token mask
	function automatic logic [1:0] first_tok(input logic [3:0] mask);
		logic [1:0] res;
		priority casez (mask)
			4'b???1: res = 2'd0;
			4'b??10: res = 2'd1;
			4'b?100: res = 2'd2;
			4'b1000: res = 2'd3;
			default: res = 2'd0;
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ece_in_if.sv @@
// ----------------------------------------------------------------------------
// ece_in_if: input text channel
// Valid/ready channel carrying one text byte and its end of message mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface ece_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_message;

	modport source(output valid, output in_byte, output end_of_message, input ready);
	modport sink(input valid, input in_byte, input end_of_message, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ece_out_if.sv @@
// ----------------------------------------------------------------------------
// ece_out_if: output text channel
// Valid/ready channel carrying one converted byte and its last flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface ece_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       message_last;

	modport source(output valid, output out_byte, output run_last, output message_last,
		input ready);
	modport sink(input valid, input out_byte, input run_last, input message_last,
		output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ece_cfg_if.sv @@
// ----------------------------------------------------------------------------
// ece_cfg_if: configuration write channel
// Valid/ready channel carrying the mode register write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface ece_cfg_if;
	logic valid;
	logic ready;
	logic decode_mode;

	modport source(output valid, output decode_mode, input ready);
	modport sink(input valid, input decode_mode, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ece_front.sv @@
// ----------------------------------------------------------------------------
// ece_front: byte classifier
// Accepts one word a cycle while the command queue has room, tracks the held
// prefix as a length and a mask of still matching tokens, and turns each word into at most one command.
// ----------------------------------------------------------------------------
`default_nettype none

module ece_front (
	input  wire logic            clk,
	input  wire logic            arst_n,
	ece_in_if.sink               feed,
	ece_cfg_if.sink              cfg,
	input  wire logic            cmd_full,
	output      logic            cmd_push,
	output      ece_pkg::ece_cmd_t cmd
);

	logic       mode_q;
	logic [3:0] hold_len_q;
	logic [3:0] alive_q;
	logic [3:0] hold_len_d;
	logic [3:0] alive_d;
	logic [3:0] match;
	logic [3:0] full;
	logic [3:0] enc_hit;
	logic       accept;

	assign feed.ready = !cmd_full;
	assign cfg.ready  = 1'b1;
	assign accept     = feed.valid && feed.ready;

	// compare the word against every token at the held position
	always_comb begin
		for (int j = 0; j < ece_pkg::NumTok; j++) begin
			match[j] = alive_q[j] && (hold_len_q < ece_pkg::TOK_LEN[j]) &&
				(ece_pkg::tok_byte(2'(j), hold_len_q) == feed.in_byte);
			full[j] = match[j] && ((hold_len_q + 4'd1) == ece_pkg::TOK_LEN[j]);
			enc_hit[j] = (feed.in_byte == ece_pkg::TOK_CHAR[j]);
		end
	end

	// build the command and the next hold state
	always_comb begin
		logic fresh;
		fresh      = 1'b0;
		cmd.tok    = 2'd0;
		cmd.n      = 4'd0;
		cmd.lit_en = 1'b0;
		cmd.lit    = feed.in_byte;
		cmd.eom    = feed.end_of_message;
		hold_len_d = hold_len_q;
		alive_d    = alive_q;
		if (!mode_q) begin
			if (|enc_hit) begin
				cmd.tok = ece_pkg::first_tok(enc_hit);
				cmd.n   = ece_pkg::TOK_LEN[ece_pkg::first_tok(enc_hit)];
			end else begin
				cmd.lit_en = 1'b1;
			end
		end else begin
			if (hold_len_q != 4'd0) begin
				priority if (|full) begin
					cmd.lit_en = 1'b1;
					cmd.lit    = ece_pkg::TOK_CHAR[ece_pkg::first_tok(full)];
					hold_len_d = 4'd0;
					alive_d    = 4'd0;
				end else if (|match) begin
					hold_len_d = hold_len_q + 4'd1;
					alive_d    = match;
				end else begin
					cmd.n   = hold_len_q;
					cmd.tok = ece_pkg::first_tok(alive_q);
					fresh   = 1'b1;
				end
			end else begin
				fresh = 1'b1;
			end
			if (fresh) begin
				if (feed.in_byte == ece_pkg::LT_CHAR) begin
					hold_len_d = 4'd1;
					alive_d    = 4'hF;
				end else begin
					cmd.lit_en = 1'b1;
					hold_len_d = 4'd0;
					alive_d    = 4'd0;
				end
			end
			// flush whatever is held at end of message
			if (feed.end_of_message && hold_len_d != 4'd0) begin
				if (cmd.n != 4'd0) begin
					cmd.lit_en = 1'b1;
					cmd.lit    = ece_pkg::LT_CHAR;
				end else begin
					cmd.n   = hold_len_d;
					cmd.tok = ece_pkg::first_tok(alive_d);
				end
				hold_len_d = 4'd0;
				alive_d    = 4'd0;
			end
		end
	end

	assign cmd_push = accept && ((cmd.n != 4'd0) || cmd.lit_en);

	// mode register and hold state; a mode write drops the hold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			hold_len_q <= 4'd0;
			alive_q    <= 4'd0;
		end else if (cfg.valid) begin
			mode_q     <= cfg.decode_mode;
			hold_len_q <= 4'd0;
			alive_q    <= 4'd0;
		end else if (accept) begin
			hold_len_q <= hold_len_d;
			alive_q    <= alive_d;
		end
	end

`ifndef SYNTH
	a_hold_depth: assert property (@(posedge clk) disable iff (!arst_n)
		hold_len_q <= 4'd8)
		else $error("hold length beyond eight bytes");
	a_hold_alive: assert property (@(posedge clk) disable iff (!arst_n)
		hold_len_q != 4'd0 |-> alive_q != 4'd0)
		else $error("held prefix matches no token");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/ece_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// ece_cmd_fifo: command queue
// Short first-in first-out queue between classifier and emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module ece_cmd_fifo #(
	parameter int unsigned Depth = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire ece_pkg::ece_cmd_t wr_cmd,
	input  wire logic              pop,
	output      ece_pkg::ece_cmd_t rd_cmd,
	output      logic              full,
	output      logic              empty
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);

	ece_pkg::ece_cmd_t slot_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign full   = (count_q == CntW'(Depth));
	assign empty  = (count_q == '0);
	assign rd_cmd = slot_q[rd_ptr_q];

	// hold pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/ece_back.sv @@
// ----------------------------------------------------------------------------
// ece_back: byte emitter
// Walks the head command one byte a cycle, while result is not stalled, into
// the output register: token bytes first, then the literal.
// ----------------------------------------------------------------------------
`default_nettype none

module ece_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ece_pkg::ece_cmd_t head,
	input  wire logic              head_valid,
	output      logic              pop,
	ece_out_if.source              result
);

	logic [3:0] pos_q;
	logic [3:0] total;
	logic       last;
	logic [7:0] cur_byte;
	logic       adv;
	logic       ov_q;
	logic [7:0] byte_q;
	logic       run_last_q;
	logic       msg_last_q;

	assign total    = head.n + {3'd0, head.lit_en};
	assign last     = ((pos_q + 4'd1) == total);
	assign cur_byte = (pos_q < head.n) ? ece_pkg::tok_byte(head.tok, pos_q) : head.lit;
	assign adv      = head_valid && (!ov_q || result.ready);
	assign pop      = adv && last;

	// output register and byte position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			pos_q <= 4'd0;
		end else if (adv) begin
			ov_q  <= 1'b1;
			pos_q <= last ? 4'd0 : pos_q + 4'd1;
		end else if (result.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q     <= cur_byte;
			run_last_q <= last;
			msg_last_q <= last && head.eom;
		end
	end

	assign result.valid        = ov_q;
	assign result.out_byte     = byte_q;
	assign result.run_last     = run_last_q;
	assign result.message_last = msg_last_q;

`ifndef SYNTH
	a_pos_in_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> pos_q < total)
		else $error("byte position past end of command");
	a_msg_last_run: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && msg_last_q |-> run_last_q)
		else $error("message end on a word that does not end its run");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/char_escape_codec.sv @@
// ----------------------------------------------------------------------------
// char_escape_codec: byte stream escape encoder and decoder
// Escapes '#', '%', '&', '$' into text tokens or restores them from tokens.
// ----------------------------------------------------------------------------
// Channels: feed takes one text byte a word with its end of message mark;
// result gives converted bytes with run_last on the last byte that a feed
// word caused and message_last on the final byte of a message. cfg writes
// decode_mode (0 encode, 1 decode); a write also drops any held prefix and
// is expected only while the block is idle.
// A word's command passes the command queue and then the output register
// before its first result byte is valid. Throughput, while result is ready:
// one feed word a cycle while each word makes at most one byte; the emitter
// gives one byte a cycle, walking a token expansion or flush of up to nine bytes. CmdDepth
// commands queue between classifier and emitter; feed.ready drops when the
// queue is full. In decode mode a word that only extends a held prefix
// gives no result.
// Reset: encode mode, nothing held, queue and output register empty.
// A stall on result holds the output register and fills the queue, then
// backs up into feed.
// ----------------------------------------------------------------------------
`default_nettype none

module char_escape_codec #(
	parameter int unsigned CmdDepth = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ece_in_if.sink    feed,
	ece_cfg_if.sink   cfg,
	ece_out_if.source result
);

	ece_pkg::ece_cmd_t push_cmd;
	ece_pkg::ece_cmd_t head_cmd;
	logic              cmd_push;
	logic              cmd_pop;
	logic              cmd_full;
	logic              cmd_empty;

	// classify incoming words
	ece_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.feed     (feed),
		.cfg      (cfg),
		.cmd_full (cmd_full),
		.cmd_push (cmd_push),
		.cmd      (push_cmd)
	);

	// queue commands
	ece_cmd_fifo #(
		.Depth (CmdDepth)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wr_cmd (push_cmd),
		.pop    (cmd_pop),
		.rd_cmd (head_cmd),
		.full   (cmd_full),
		.empty  (cmd_empty)
	);

	// emit bytes
	ece_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_cmd),
		.head_valid (!cmd_empty),
		.pop        (cmd_pop),
		.result     (result)
	);

endmodule

`default_nettype wire
